// File: rtl/all_words_substring_match_macros.svh
// Assertion macros for the checker file of the substring matcher.
`ifndef ALL_WORDS_SUBSTRING_MATCH_MACROS_SVH
`define ALL_WORDS_SUBSTRING_MATCH_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AWSM_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define AWSM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/awsm_pkg.sv
// Shared constants, register codes and helpers of the substring matcher.
package awsm_pkg;

    localparam int BYTE_W               = 8;
    localparam int WORD_REGS            = 4;
    localparam int CHARS_PER_REG        = 8;
    localparam int CFG_DATA_W           = 64;
    localparam int CFG_IDX_W            = 3;
    localparam int FOUND_W              = 4;
    localparam int LEN_FIELD_W          = 4;
    localparam int COUNT_FIELD_W        = 3;
    localparam int MAX_WORDS_DEFAULT    = 4;
    localparam int MAX_WORD_LEN_DEFAULT = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHARS_0 = 3'd0,
        REG_CHARS_1 = 3'd1,
        REG_CHARS_2 = 3'd2,
        REG_CHARS_3 = 3'd3,
        REG_LENGTHS = 3'd4,
        REG_COUNT   = 3'd5
    } cfg_reg_t;

    function automatic int min_int(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

endpackage

// File: rtl/all_words_substring_match.sv
// Top level: streams line bytes and reports whether every query word occurred.
//
//  channel | signals                              | direction | word
//  --------+--------------------------------------+-----------+--------------------------
//  cfg     | cfg_write cfg_index cfg_data         | in        | register write, no stall
//  in      | in_valid in_ready                    | in        | line_byte, end_of_line
//  out     | out_valid out_ready                  | out       | line_matches, words_found
//
//  One byte per cycle unless a line end stalls. A byte sits in the input register
//  while all word comparators check it against the window; its line result, if it
//  ends a line, is registered from there into the output register.
//  Only a line-end byte can wait: it holds in the input register while the
//  output register is full and not being taken, which drops in_ready.
//  rst_n clears the pipeline valids, the seen count, the found mask and the query
//  registers to their reset values (word_active reads as one word active).
module all_words_substring_match
    import awsm_pkg::*;
#(
    parameter int MAX_WORDS    = MAX_WORDS_DEFAULT,
    parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [BYTE_W-1:0]       line_byte,
    input  logic                    end_of_line,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    line_matches,
    output logic [FOUND_W-1:0]      words_found
);

    // only as many words and chars as the registers can hold take effect
    localparam int NUM_WORDS  = min_int(WORD_REGS, MAX_WORDS);
    localparam int WIN_LEN    = min_int(CHARS_PER_REG, MAX_WORD_LEN);
    localparam int HIST_DEPTH = (WIN_LEN > 1) ? WIN_LEN - 1 : 1;
    localparam int CNT_W      = $clog2(WIN_LEN + 1);

    logic [WIN_LEN*BYTE_W-1:0]  word_chars [NUM_WORDS];
    logic [CNT_W-1:0]           word_len   [NUM_WORDS];
    logic [NUM_WORDS-1:0]       word_active;

    // input register
    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic [BYTE_W-1:0]          s1_byte_reg;
    logic                       s1_eol_reg;

    // line progress
    logic [BYTE_W-1:0]          hist_reg  [HIST_DEPTH];   // newest first
    logic [BYTE_W-1:0]          hist_next [HIST_DEPTH];
    logic [CNT_W-1:0]           seen_reg;
    logic [CNT_W-1:0]           seen_next;
    logic [CNT_W-1:0]           seen_now;
    logic [NUM_WORDS-1:0]       found_reg;
    logic [NUM_WORDS-1:0]       found_next;
    logic [NUM_WORDS-1:0]       found_now;
    logic [NUM_WORDS-1:0]       hit;
    logic [WIN_LEN*BYTE_W-1:0]  win_bytes;

    // output register
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       line_matches_reg;
    logic                       line_matches_next;
    logic [FOUND_W-1:0]         words_found_reg;
    logic [FOUND_W-1:0]         words_found_next;

    logic                       fire;
    logic                       in_take;

    awsm_cfg_regs #(
        .NUM_WORDS (NUM_WORDS),
        .WIN_LEN   (WIN_LEN),
        .CNT_W     (CNT_W)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .word_chars  (word_chars),
        .word_len    (word_len),
        .word_active (word_active)
    );

    // byte 0 of the window is the byte under test, then older ones
    always_comb
    begin
        win_bytes[BYTE_W-1:0] = s1_byte_reg;
        for (int i = 1; i < WIN_LEN; i++)
        begin
            win_bytes[i*BYTE_W +: BYTE_W] = hist_reg[i-1];
        end
    end

    assign seen_now = (seen_reg == CNT_W'(WIN_LEN)) ? seen_reg : seen_reg + 1'b1;

    for (genvar w = 0; w < NUM_WORDS; w++)
    begin : g_word
        awsm_word_match #(
            .WIN_LEN (WIN_LEN),
            .CNT_W   (CNT_W)
        ) u_match (
            .win_bytes  (win_bytes),
            .seen       (seen_now),
            .word_chars (word_chars[w]),
            .word_len   (word_len[w]),
            .hit        (hit[w])
        );
    end

    assign found_now = found_reg | (hit & word_active);

    // a line end needs a free output slot; other bytes never wait
    assign fire     = s1_valid_reg && (!s1_eol_reg || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || fire;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next     = in_take ? 1'b1 : (fire ? 1'b0 : s1_valid_reg);
        hist_next         = hist_reg;
        seen_next         = seen_reg;
        found_next        = found_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        line_matches_next = line_matches_reg;
        words_found_next  = words_found_reg;
        if (fire)
        begin
            if (s1_eol_reg)
            begin
                out_valid_next    = 1'b1;
                line_matches_next = ((found_now & word_active) == word_active);
                words_found_next  = FOUND_W'(found_now & word_active);
                seen_next         = '0;
                found_next        = '0;
            end
            else
            begin
                hist_next[0] = s1_byte_reg;
                for (int i = 1; i < HIST_DEPTH; i++)
                begin
                    hist_next[i] = hist_reg[i-1];
                end
                seen_next  = seen_now;
                found_next = found_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            seen_reg      <= '0;
            found_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            seen_reg      <= seen_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= line_byte;
            s1_eol_reg  <= end_of_line;
        end
        hist_reg         <= hist_next;
        line_matches_reg <= line_matches_next;
        words_found_reg  <= words_found_next;
    end

    assign out_valid    = out_valid_reg;
    assign line_matches = line_matches_reg;
    assign words_found  = words_found_reg;

endmodule

// File: rtl/awsm_cfg_regs.sv
// Query word register file: decode, length clamp and active-word mask.
module awsm_cfg_regs
    import awsm_pkg::*;
#(
    parameter int NUM_WORDS = 4,
    parameter int WIN_LEN   = 8,
    parameter int CNT_W     = 4
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    output logic [WIN_LEN*BYTE_W-1:0]   word_chars [NUM_WORDS],
    output logic [CNT_W-1:0]            word_len   [NUM_WORDS],
    output logic [NUM_WORDS-1:0]        word_active
);

    logic                        sel_chars;
    logic                        sel_len;
    logic                        sel_count;
    logic [NUM_WORDS-1:0]        wr_chars;
    logic [LEN_FIELD_W-1:0]      len_field [NUM_WORDS];
    logic [CNT_W-1:0]            len_next  [NUM_WORDS];
    logic [NUM_WORDS-1:0]        active_next;
    logic [WIN_LEN*BYTE_W-1:0]   chars_reg [NUM_WORDS];
    logic [CNT_W-1:0]            len_reg   [NUM_WORDS];
    logic [NUM_WORDS-1:0]        active_reg;

    always_comb
    begin
        sel_chars = 1'b0;
        sel_len   = 1'b0;
        sel_count = 1'b0;
        unique case (cfg_index) inside
            REG_CHARS_0, REG_CHARS_1, REG_CHARS_2, REG_CHARS_3: sel_chars = cfg_write;
            REG_LENGTHS: sel_len   = cfg_write;
            REG_COUNT:   sel_count = cfg_write;
            default:     ;
        endcase
    end

    // lengths clamp to the window; count clamps by keeping only NUM_WORDS bits
    always_comb
    begin
        for (int w = 0; w < NUM_WORDS; w++)
        begin
            wr_chars[w]    = sel_chars && (cfg_index[1:0] == 2'(w));
            len_field[w]   = cfg_data[LEN_FIELD_W*w +: LEN_FIELD_W];
            len_next[w]    = (len_field[w] > LEN_FIELD_W'(WIN_LEN)) ?
                             CNT_W'(WIN_LEN) : CNT_W'(len_field[w]);
            active_next[w] = COUNT_FIELD_W'(w) < cfg_data[COUNT_FIELD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < NUM_WORDS; w++)
            begin
                chars_reg[w] <= '0;
                len_reg[w]   <= '0;
            end
            active_reg <= NUM_WORDS'(1);
        end
        else
        begin
            for (int w = 0; w < NUM_WORDS; w++)
            begin
                if (wr_chars[w])
                begin
                    chars_reg[w] <= cfg_data[WIN_LEN*BYTE_W-1:0];
                end
                if (sel_len)
                begin
                    len_reg[w] <= len_next[w];
                end
            end
            if (sel_count)
            begin
                active_reg <= active_next;
            end
        end
    end

    assign word_chars  = chars_reg;
    assign word_len    = len_reg;
    assign word_active = active_reg;

endmodule

// File: rtl/awsm_word_match.sv
// Compares one query word against the byte window ending at the current byte.
module awsm_word_match
    import awsm_pkg::*;
#(
    parameter int WIN_LEN = 8,
    parameter int CNT_W   = 4
)
(
    input  logic [WIN_LEN*BYTE_W-1:0]   win_bytes,
    input  logic [CNT_W-1:0]            seen,
    input  logic [WIN_LEN*BYTE_W-1:0]   word_chars,
    input  logic [CNT_W-1:0]            word_len,
    output logic                        hit
);

    // match_len[L-1]: word's first L chars equal the last L bytes, oldest first
    logic [WIN_LEN-1:0] match_len;
    logic               len_hit;

    always_comb
    begin
        for (int l = 1; l <= WIN_LEN; l++)
        begin
            match_len[l-1] = 1'b1;
            for (int k = 0; k < l; k++)
            begin
                if (win_bytes[(l-1-k)*BYTE_W +: BYTE_W] != word_chars[k*BYTE_W +: BYTE_W])
                begin
                    match_len[l-1] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        len_hit = 1'b0;
        for (int l = 1; l <= WIN_LEN; l++)
        begin
            if (word_len == CNT_W'(l))
            begin
                len_hit = match_len[l-1];
            end
        end
        if (word_len == '0)
        begin
            hit = 1'b1;
        end
        else if (seen < word_len)
        begin
            hit = 1'b0;
        end
        else
        begin
            hit = len_hit;
        end
    end

endmodule

// File: rtl/awsm_checker.sv
// Port-level checker of the substring matcher and its bind to the top level.
`include "all_words_substring_match_macros.svh"

module awsm_checker
    import awsm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                end_of_line,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic                line_matches,
    input  logic [FOUND_W-1:0]  words_found
);

    // lines accepted whose result is not yet taken
    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       eol_take;
    logic       out_take;

    assign eol_take = in_valid && in_ready && end_of_line;
    assign out_take = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg + 2'(eol_take) - 2'(out_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `AWSM_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(line_matches) && $stable(words_found),
        "stalled result changed")
    `AWSM_ASSERT(a_no_invented, out_valid, pending_reg != 2'd0 && pending_reg != 2'd3,
        "result without a pending line or too many lines in flight")
    `AWSM_ASSERT(a_ready_when_empty, !out_valid, in_ready,
        "input stalled while output register is empty")
    `AWSM_ASSERT(a_stall_when_full, out_valid && !out_ready && pending_reg == 2'd2,
        !in_ready, "input taken while both line slots are full")

endmodule

bind all_words_substring_match awsm_checker u_awsm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .end_of_line  (end_of_line),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .line_matches (line_matches),
    .words_found  (words_found)
);

// File: tb/all_words_substring_match_test.sv
// Testbench for the all-words substring matcher: self-predicting scoreboard with random traffic.
`timescale 1ns / 100ps

module all_words_substring_match_test;
    import awsm_pkg::*;

    localparam int MAX_WORDS    = MAX_WORDS_DEFAULT;
    localparam int MAX_WORD_LEN = MAX_WORD_LEN_DEFAULT;
    // Edges from an accepted line-end byte until its verdict can be taken.
    localparam int PIPE_LATENCY = 2;
    // Indexes past the last register; the block must ignore writes to them.
    localparam logic [CFG_IDX_W-1:0] SPARE_REG_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] SPARE_REG_HI = 3'd7;
    // Filler text leans on a three-letter alphabet so planted and chance matches are common.
    localparam logic [BYTE_W-1:0] LETTER_A = "a";
    localparam int RANDOM_SETUPS   = 10;
    localparam int BYTES_PER_SETUP = 90;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct packed {
        logic               all_hit;
        logic [FOUND_W-1:0] found;
    } line_verdict_t;

    // Mirrors the register file and line progress of the matcher, predicts one verdict
    // per line end and compares the block's verdicts against them in order.
    class line_match_scoreboard;
        logic [CFG_DATA_W-1:0]     word_chars [WORD_REGS];
        logic [15:0]               word_lengths;
        logic [COUNT_FIELD_W-1:0]  word_count;
        logic [BYTE_W-1:0]         history [MAX_WORD_LEN];
        int                        line_fill;
        logic [FOUND_W-1:0]        seen_words;
        line_verdict_t             pending_verdicts [$];
        int unsigned               mismatches;
        int unsigned               lines_checked;
        int unsigned               bytes_noted;

        function new();
            foreach (word_chars[i]) word_chars[i] = '0;
            word_lengths  = '0;
            word_count    = 1;
            mismatches    = 0;
            lines_checked = 0;
            bytes_noted   = 0;
            clear_line();
        endfunction

        function void clear_line();
            foreach (history[i]) history[i] = '0;
            line_fill  = 0;
            seen_words = '0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_CHARS_0, REG_CHARS_1, REG_CHARS_2, REG_CHARS_3: word_chars[idx[1:0]] = data;
                REG_LENGTHS: word_lengths = data[15:0];
                REG_COUNT:   word_count   = data[COUNT_FIELD_W-1:0];
                default: ;
            endcase
        endfunction

        function int active_count();
            int n;
            n = word_count;
            if (n > WORD_REGS) n = WORD_REGS;
            if (n > MAX_WORDS) n = MAX_WORDS;
            return n;
        endfunction

        function int clamped_length(int w);
            int len;
            len = word_lengths[LEN_FIELD_W*w +: LEN_FIELD_W];
            if (len > CHARS_PER_REG) len = CHARS_PER_REG;
            if (len > MAX_WORD_LEN) len = MAX_WORD_LEN;
            return len;
        endfunction

        // True if word w ends on the current byte; fill counts bytes including it.
        function bit word_ends_at(int w, logic [BYTE_W-1:0] cur, int fill);
            int len;
            int back;
            logic [BYTE_W-1:0] got;
            len = clamped_length(w);
            if (len == 0) return 1'b1;
            if (fill < len) return 1'b0;
            for (int k = 0; k < len; k++) begin
                back = len - 1 - k;
                got  = (back == 0) ? cur : history[back-1];
                if (got != word_chars[w][BYTE_W*k +: BYTE_W]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b, logic last);
            int n;
            int fill;
            logic [FOUND_W-1:0] all_mask;
            line_verdict_t v;
            bytes_noted++;
            n    = active_count();
            fill = line_fill + 1;
            if (fill > MAX_WORD_LEN) fill = MAX_WORD_LEN;
            for (int w = 0; w < n; w++)
                if (word_ends_at(w, b, fill)) seen_words[w] = 1'b1;
            if (last) begin
                all_mask  = FOUND_W'((1 << n) - 1);
                v.all_hit = ((seen_words & all_mask) == all_mask);
                v.found   = seen_words & all_mask;
                pending_verdicts.push_back(v);
                clear_line();
            end
            else begin
                for (int i = MAX_WORD_LEN - 1; i > 0; i--) history[i] = history[i-1];
                history[0] = b;
                line_fill  = fill;
            end
        endfunction

        task flag_mismatch(string what);
            if (mismatches < 20) $display("[%0t] line verdict mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_line(logic got_match, logic [FOUND_W-1:0] got_found);
            line_verdict_t want;
            lines_checked++;
            if (pending_verdicts.size() == 0) begin
                flag_mismatch("verdict with no line end waiting");
                return;
            end
            want = pending_verdicts.pop_front();
            if (got_match !== want.all_hit)
                flag_mismatch($sformatf("line_matches %b, predicted %b", got_match, want.all_hit));
            if (got_found !== want.found)
                flag_mismatch($sformatf("words_found %b, predicted %b", got_found, want.found));
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [BYTE_W-1:0]      line_byte;
    logic                   end_of_line;
    logic                   out_valid;
    logic                   out_ready;
    logic                   line_matches;
    logic [FOUND_W-1:0]     words_found;

    line_match_scoreboard   sb;
    logic [BYTE_W-1:0]      line_text [$];   // line being assembled for sending
    int                     burst_left;
    int                     bytes_offered;
    int                     setups;
    bit                     held_off;

    all_words_substring_match #(
        .MAX_WORDS    (MAX_WORDS),
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .line_byte    (line_byte),
        .end_of_line  (end_of_line),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .line_matches (line_matches),
        .words_found  (words_found)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Monitors sample pre-edge values, so they see exactly what the block sampled.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready) sb.note_byte(line_byte, end_of_line);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) sb.check_line(line_matches, words_found);
    end

    // Output side: stall pattern changes from span to span between always ready,
    // coin flip and mostly stalled. Once, after some verdicts have come back, it holds
    // off for a long stretch so the output register fills and the line-end byte backs up.
    initial
    begin
        int mode;
        int span;
        out_ready = 1'b0;
        held_off  = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(16, 96);
            repeat (span) begin
                @(posedge clk);
                if (!held_off && sb.lines_checked >= 40) begin
                    held_off = 1'b1;
                    out_ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(posedge clk);
                end
                else begin
                    case (mode)
                        0: out_ready <= 1'b1;
                        1: out_ready <= ($urandom_range(0, 1) == 1);
                        default: out_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    initial
    begin
        #400000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [BYTE_W-1:0] pick_char();
        if ($urandom_range(0, 9) < 8) return LETTER_A + BYTE_W'($urandom_range(0, 2));
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [LEN_FIELD_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return LEN_FIELD_W'($urandom_range(1, 4));
        if (r < 8) return LEN_FIELD_W'($urandom_range(5, 8));
        if (r == 8) return '0;
        return LEN_FIELD_W'($urandom_range(9, 15));   // clamps to eight
    endfunction

    // Offers one byte. The sender runs in bursts; between bursts valid drops for a
    // random gap. Valid is never lowered and raised in the same step.
    task automatic put_byte(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 12);
        end
        in_valid    <= 1'b1;
        line_byte   <= b;
        end_of_line <= last;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        bytes_offered++;
    endtask

    task automatic send_line();
        foreach (line_text[i]) put_byte(line_text[i], i == line_text.size() - 1);
    endtask

    // Block idle: input quiet, every verdict back, pipeline flushed.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_verdicts.size() != 0) @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_register(idx, data);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Fresh word set. Setup 0 uses full eight-byte words, setup 1 the register
    // extremes (all-ones text, length nibbles of fifteen, count seven), setup 2
    // only empty words; the rest are random.
    task automatic load_words(input int setup);
        logic [CFG_DATA_W-1:0]    chars;
        logic [15:0]              lens;
        logic [COUNT_FIELD_W-1:0] cnt;
        int r;
        for (int i = 0; i < WORD_REGS; i++) begin
            for (int k = 0; k < CHARS_PER_REG; k++) chars[BYTE_W*k +: BYTE_W] = pick_char();
            if (setup == 1) chars = '1;
            write_reg(CFG_IDX_W'(REG_CHARS_0 + i), chars);
        end
        for (int k = 0; k < WORD_REGS; k++) lens[LEN_FIELD_W*k +: LEN_FIELD_W] = pick_length();
        r = $urandom_range(0, 9);
        if (r < 7) cnt = COUNT_FIELD_W'($urandom_range(1, 4));
        else if (r == 7) cnt = 0;
        else cnt = COUNT_FIELD_W'($urandom_range(5, 7));
        case (setup)
            0: begin lens = 16'h8888; cnt = 4; end
            1: begin lens = 16'hFFFF; cnt = 7; end
            2: begin lens = 16'h0000; cnt = 4; end
            default: ;
        endcase
        write_reg(REG_LENGTHS, lens);
        write_reg(REG_COUNT, cnt);
        if ($urandom_range(0, 1) == 1)
            write_reg($urandom_range(0, 1) ? SPARE_REG_HI : SPARE_REG_LO, {$urandom, $urandom});
        setups++;
    endtask

    // Mostly filler with configured words planted in it; some plants are cut
    // short by one byte, and some lines are pure filler or long.
    task automatic send_random_line();
        int len;
        int plants;
        int w;
        int wl;
        int pos;
        len = ($urandom_range(0, 9) == 9) ? $urandom_range(20, 40) : $urandom_range(1, 10);
        line_text.delete();
        repeat (len) line_text.push_back(pick_char());
        plants = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : 0;
        repeat (plants) begin
            w  = $urandom_range(0, WORD_REGS - 1);
            wl = sb.clamped_length(w);
            if (wl > 0 && $urandom_range(0, 4) == 0) wl--;
            pos = $urandom_range(0, line_text.size());
            for (int k = 0; k < wl; k++)
                line_text.insert(pos + k, sb.word_chars[w][BYTE_W*k +: BYTE_W]);
        end
        send_line();
    endtask

    initial
    begin
        int setup_start;
        sb            = new();
        burst_left    = 0;
        bytes_offered = 0;
        setups        = 0;
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        line_byte     = '0;
        end_of_line   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state: one active word of length zero, so any line matches.
        line_text = {8'hFF};
        send_line();
        settle();

        // "ab", eight 0xFF bytes, length nibble fifteen over zero bytes, empty word;
        // count seven must clamp to four. Spare indexes must not disturb anything.
        write_reg(REG_CHARS_0, {48'h0, "ba"});   // first char in low byte
        write_reg(REG_CHARS_1, '1);
        write_reg(REG_CHARS_2, '0);
        write_reg(REG_CHARS_3, 64'h5555_AAAA_5555_AAAA);
        write_reg(REG_LENGTHS, 16'h0F82);
        write_reg(REG_COUNT, 7);
        write_reg(SPARE_REG_LO, '0);
        write_reg(SPARE_REG_HI, '1);
        line_text = {"x", "a", "b"};              // eight-byte words longer than the line
        send_line();
        line_text.delete();
        repeat (8) line_text.push_back(8'hFF);    // full-width word fills the window
        send_line();
        line_text.delete();
        repeat (7) line_text.push_back(8'h00);    // zero history must not count as seen
        send_line();
        settle();

        // No active words: every line matches with an empty found mask.
        write_reg(REG_COUNT, 0);
        line_text = {8'h00};
        send_line();
        settle();

        // Reconfigure mid-line: "a" is found under the old length before the
        // word grows to "ab", and stays found.
        write_reg(REG_COUNT, 1);
        write_reg(REG_LENGTHS, 16'h0001);
        put_byte("a", 1'b0);
        settle();
        write_reg(REG_LENGTHS, 16'h0002);
        put_byte("c", 1'b1);

        for (int s = 0; s < RANDOM_SETUPS; s++) begin
            settle();
            load_words(s);
            setup_start = bytes_offered;
            while (bytes_offered - setup_start < BYTES_PER_SETUP) send_random_line();
        end

        settle();
        $display("Streamed %0d line bytes, checked %0d line verdicts across %0d random word setups.",
                 sb.bytes_noted, sb.lines_checked, setups);
        $display("Long output hold-off %s; %0d mismatches.",
                 held_off ? "exercised" : "not reached", sb.mismatches);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
